// ===== src/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types, codes and sizes for the key/value table core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  localparam int unsigned KeyW        = 32;
  localparam int unsigned ValW        = 32;
  localparam int unsigned ModeW       = 3;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned StW         = 2;
  localparam int unsigned CntOutW     = 7;
  localparam int unsigned DefCapacity = 64;

  localparam logic [ModeW-1:0] ModePut    = 3'd0;
  localparam logic [ModeW-1:0] ModeAcc    = 3'd1;
  localparam logic [ModeW-1:0] ModeLookup = 3'd2;
  localparam logic [ModeW-1:0] ModeRemove = 3'd3;
  localparam logic [ModeW-1:0] ModeRead   = 3'd4;

  localparam logic [StW-1:0] StOk       = 2'd0;
  localparam logic [StW-1:0] StNotFound = 2'd1;
  localparam logic [StW-1:0] StFull     = 2'd2;
  localparam logic [StW-1:0] StEmpty    = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]       mode;
    logic [KeyW-1:0]        key;
    logic signed [ValW-1:0] value;
    logic [IdxW-1:0]        index;
  } kvt_req_t;

  typedef struct packed {
    logic [StW-1:0]         status;
    logic                   found;
    logic [KeyW-1:0]        key_out;
    logic signed [ValW-1:0] value_out;
    logic [CntOutW-1:0]     entry_count;
  } kvt_rsp_t;

  // broadcast to every cell in the compare cycle
  typedef struct packed {
    logic            en;
    logic            by_pos;
    logic [KeyW-1:0] key;
  } kvt_cmp_t;

  // broadcast to every cell in the update cycle
  typedef struct packed {
    logic            wr_en;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } kvt_upd_t;

endpackage

`default_nettype wire

// ===== src/kvt_cell.sv =====
// ----------------------------------------------------------------------------
// kvt_cell
// One table entry: key and value registers, a local key compare and the
// shift path from the next cell used to close the gap on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire kvt_pkg::kvt_cmp_t        cmp_i,
  input  wire kvt_pkg::kvt_upd_t        upd_i,
  input  wire logic                     valid_i,
  input  wire logic                     pos_sel_i,
  input  wire logic                     append_i,
  input  wire logic                     shift_i,
  input  wire logic [kvt_pkg::KeyW-1:0] nxt_key_i,
  input  wire logic [kvt_pkg::ValW-1:0] nxt_value_i,
  output logic      [kvt_pkg::KeyW-1:0] key_o,
  output logic      [kvt_pkg::ValW-1:0] value_o,
  output logic                          hit_o
);
  import kvt_pkg::*;

  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;
  logic            hit_q, hit_d;

  always_comb begin
    hit_d = hit_q;
    if (cmp_i.en) begin
      hit_d = valid_i && (cmp_i.by_pos ? pos_sel_i : (key_q == cmp_i.key));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // entries are not reset; validity comes from the table's fill count
  always_ff @(posedge clk_i) begin
    priority if (shift_i) begin
      key_q   <= nxt_key_i;
      value_q <= nxt_value_i;
    end else if (append_i) begin
      key_q   <= upd_i.key;
      value_q <= upd_i.value;
    end else if (upd_i.wr_en && hit_q) begin
      value_q <= upd_i.value;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

// ===== src/key_value_table_core.sv =====
// ----------------------------------------------------------------------------
// key_value_table_core
// Ordered key/value table held in a row of entry cells, kept in insertion
// order, with put, put-accumulate, lookup, remove and read-by-index.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (req_i) is taken at a rising edge where start is high and
//   busy is low. The response word (rsp_o) is flagged by done_o, which is high
//   for exactly one cycle, and cannot be held off by the receiver.
//   Each command runs as a compare cycle, where every cell checks its key
//   (or its position for read-by-index) against the command, then an
//   update cycle, where the single matching cell is selected, the table is
//   written and the response is registered. done_o rises in the cycle
//   after the update cycle. busy is high only during the compare cycle, so
//   a new command can be taken in the update cycle of the previous one; the
//   compare of the next command overlaps the output of the previous one.
//   Remove shifts every later cell down by one in the update cycle, so
//   order is kept. Reset empties the table (fill count zero) and drops any
//   command in flight; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table_core #(
  parameter int unsigned CAPACITY = kvt_pkg::DefCapacity
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire kvt_pkg::kvt_req_t req_i,
  output logic                   done_o,
  output kvt_pkg::kvt_rsp_t      rsp_o
);
  import kvt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > IdxW) ? CW : IdxW;

  // two-step sequence: compare, then update
  logic     cmp_q, upd_q;
  kvt_req_t req_q, req2_q;
  logic [CW-1:0] count_q, count_d;
  logic     done_q;
  kvt_rsp_t rsp_q, rsp_d;

  logic [CAPACITY-1:0] valid, pos_sel, append, shift, hit;
  logic [KeyW-1:0]     cell_key [CAPACITY];
  logic [ValW-1:0]     cell_val [CAPACITY];
  logic [KeyW-1:0]     nxt_key  [CAPACITY];
  logic [ValW-1:0]     nxt_val  [CAPACITY];

  kvt_cmp_t cmp;
  kvt_upd_t upd;

  logic [XW-1:0]   idx_x, cnt_x, rd_pos_x;
  logic [IW-1:0]   rd_pos, hit_pos;
  logic            found;
  logic [KeyW-1:0] sel_key;
  logic [ValW-1:0] sel_val, sum_val;
  logic            is_put, full, app_en, rm_en;

  wire accept = start && !busy;
  assign busy = cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q   <= 1'b0;
      upd_q   <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      cmp_q   <= accept;
      upd_q   <= cmp_q;
      done_q  <= upd_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (cmp_q) begin
      req2_q <= req_q;
    end
    if (upd_q) begin
      rsp_q <= rsp_d;
    end
  end

  // read position: clamp to the last entry
  always_comb begin
    idx_x    = XW'(req_q.index);
    cnt_x    = XW'(count_q);
    rd_pos_x = (idx_x >= cnt_x) ? (cnt_x - XW'(1)) : idx_x;
    rd_pos   = rd_pos_x[IW-1:0];
  end

  always_comb begin
    cmp.en     = cmp_q;
    cmp.by_pos = (req_q.mode == ModeRead);
    cmp.key    = req_q.key;
  end

  // one-hot select of the single hit cell (keys are unique)
  always_comb begin
    sel_key = '0;
    sel_val = '0;
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        sel_key = sel_key | cell_key[i];
        sel_val = sel_val | cell_val[i];
        hit_pos = hit_pos | IW'(i);
      end
    end
    found = |hit;
  end

  assign sum_val = sel_val + req2_q.value;
  assign is_put  = (req2_q.mode == ModePut) || (req2_q.mode == ModeAcc);
  assign full    = (count_q >= CW'(CAPACITY));
  assign app_en  = upd_q && is_put && !found && !full;
  assign rm_en   = upd_q && (req2_q.mode == ModeRemove) && found;

  always_comb begin
    upd.wr_en = upd_q && is_put && found;
    upd.key   = req2_q.key;
    upd.value = (req2_q.mode == ModeAcc && found) ? sum_val : req2_q.value;
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i]   = (CW'(i) < count_q);
      pos_sel[i] = (rd_pos == IW'(i));
      append[i]  = app_en && (CW'(i) == count_q);
      shift[i]   = rm_en && (IW'(i) >= hit_pos);
      if (i + 1 < CAPACITY) begin
        nxt_key[i] = cell_key[(i + 1) % CAPACITY];
        nxt_val[i] = cell_val[(i + 1) % CAPACITY];
      end else begin
        nxt_key[i] = '0;
        nxt_val[i] = '0;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    kvt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmp_i       (cmp),
      .upd_i       (upd),
      .valid_i     (valid[g]),
      .pos_sel_i   (pos_sel[g]),
      .append_i    (append[g]),
      .shift_i     (shift[g]),
      .nxt_key_i   (nxt_key[g]),
      .nxt_value_i (nxt_val[g]),
      .key_o       (cell_key[g]),
      .value_o     (cell_val[g]),
      .hit_o       (hit[g])
    );
  end

  always_comb begin
    count_d           = count_q;
    rsp_d.status      = StOk;
    rsp_d.found       = 1'b0;
    rsp_d.key_out     = '0;
    rsp_d.value_out   = '0;
    if (upd_q) begin
      unique case (req2_q.mode)
        ModePut, ModeAcc: begin
          if (found) begin
            rsp_d.found     = 1'b1;
            rsp_d.value_out = upd.value;
          end else if (full) begin
            rsp_d.status = StFull;
          end else begin
            rsp_d.value_out = req2_q.value;
            count_d         = count_q + CW'(1);
          end
        end
        ModeLookup: begin
          if (found) begin
            rsp_d.found     = 1'b1;
            rsp_d.value_out = sel_val;
          end else begin
            rsp_d.status = StNotFound;
          end
        end
        ModeRemove: begin
          if (found) begin
            rsp_d.found     = 1'b1;
            rsp_d.value_out = sel_val;
            count_d         = count_q - CW'(1);
          end else begin
            rsp_d.status = StNotFound;
          end
        end
        ModeRead: begin
          if (count_q == '0) begin
            rsp_d.status = StEmpty;
          end else begin
            rsp_d.key_out   = sel_key;
            rsp_d.value_out = sel_val;
          end
        end
        default: begin
        end
      endcase
    end
    rsp_d.entry_count = CntOutW'(count_d);
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
